// ===== hdl/lmem_pkg.sv =====
`timescale 1ns / 1ps

package lmem_pkg;

    // Event codes carried in the opcode field.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2,
        OP_NONCE = 2'd3
    } t_opcode;

    localparam int OUT_BITS     = 32;
    localparam int NONCE_BITS   = 64;
    localparam int ALPHA_BITS   = 16;
    localparam int ALPHA_FRAC   = 16;
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd13107;

    localparam int S_TDATA_BITS = 64;
    localparam int S_TUSER_BITS = 2;
    localparam int M_TDATA_BITS = 200;

    // One result as seen on the master side.
    typedef struct packed {
        logic [OUT_BITS-1:0]   average;
        logic [OUT_BITS-1:0]   minimum;
        logic [OUT_BITS-1:0]   maximum;
        logic                  running;
        logic [OUT_BITS-1:0]   pending;
        logic                  nonce_present;
        logic [NONCE_BITS-1:0] nonce_out;
    } t_result;

endpackage

// ===== hdl/lmem_core.sv =====
`timescale 1ns / 1ps

module lmem_core #(
    parameter int DURATION_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  lmem_pkg::t_opcode                 i_opcode,
    input  logic [lmem_pkg::NONCE_BITS-1:0]   i_nonce,
    input  logic [lmem_pkg::ALPHA_BITS-1:0]   i_alpha,
    output lmem_pkg::t_result                 o_result
);

    localparam int DB = DURATION_BITS;
    localparam int OB = lmem_pkg::OUT_BITS;
    localparam int AB = lmem_pkg::ALPHA_BITS;
    localparam int FB = lmem_pkg::ALPHA_FRAC;
    localparam int PB = DB + AB + 2;

    logic                            r_in_progress, n_in_progress;
    logic [DB-1:0]                   r_elapsed, n_elapsed;
    logic [DB-1:0]                   r_average, n_average;
    logic [DB-1:0]                   r_minimum, n_minimum;
    logic [DB-1:0]                   r_maximum, n_maximum;
    logic                            r_nonce_valid, n_nonce_valid;
    logic [lmem_pkg::NONCE_BITS-1:0] r_nonce_store, n_nonce_store;

    logic signed [DB:0]   diff;
    logic signed [AB:0]   alpha_s;
    logic signed [PB-1:0] prod;
    logic [DB-1:0]        ema;
    logic [DB-1:0]        pending;

    // avg + floor(alpha * (d - avg) / 2^16) is the same as the two-product form,
    // and the slice of the signed product is the floor.
    always_comb begin
        diff    = $signed({1'b0, r_elapsed}) - $signed({1'b0, r_average});
        alpha_s = $signed({1'b0, i_alpha});
        prod    = alpha_s * diff;
        ema     = r_average + prod[DB+FB-1:FB];
    end

    always_comb begin
        n_in_progress = r_in_progress;
        n_elapsed     = r_elapsed;
        n_average     = r_average;
        n_minimum     = r_minimum;
        n_maximum     = r_maximum;
        n_nonce_valid = r_nonce_valid;
        n_nonce_store = r_nonce_store;
        unique case (i_opcode)
            lmem_pkg::OP_TICK: begin
                if (r_in_progress && !(&r_elapsed)) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end
            lmem_pkg::OP_START: begin
                if (!r_in_progress) begin
                    n_elapsed     = '0;
                    n_in_progress = 1'b1;
                end
            end
            lmem_pkg::OP_END: begin
                if (r_in_progress) begin
                    n_in_progress = 1'b0;
                    n_nonce_valid = 1'b0;
                    n_nonce_store = '0;
                    if (r_average == '0) begin
                        n_average = r_elapsed;
                        n_minimum = r_elapsed;
                        n_maximum = r_elapsed;
                    end else begin
                        n_average = ema;
                        if (r_elapsed < r_minimum) begin
                            n_minimum = r_elapsed;
                        end
                        if (r_elapsed > r_maximum) begin
                            n_maximum = r_elapsed;
                        end
                    end
                end
            end
            lmem_pkg::OP_NONCE: begin
                n_nonce_store = i_nonce;
                n_nonce_valid = 1'b1;
            end
            default: begin
                n_in_progress = r_in_progress;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_progress <= 1'b0;
            r_elapsed     <= '0;
            r_average     <= '0;
            r_minimum     <= '0;
            r_maximum     <= '0;
            r_nonce_valid <= 1'b0;
            r_nonce_store <= '0;
        end else if (i_step) begin
            r_in_progress <= n_in_progress;
            r_elapsed     <= n_elapsed;
            r_average     <= n_average;
            r_minimum     <= n_minimum;
            r_maximum     <= n_maximum;
            r_nonce_valid <= n_nonce_valid;
            r_nonce_store <= n_nonce_store;
        end
    end

    assign pending = n_in_progress ? n_elapsed : '0;

    // Durations wider than the result fields show their low bits.
    generate
        if (DB >= OB) begin : g_trunc
            assign o_result.average = n_average[OB-1:0];
            assign o_result.minimum = n_minimum[OB-1:0];
            assign o_result.maximum = n_maximum[OB-1:0];
            assign o_result.pending = pending[OB-1:0];
        end else begin : g_extend
            assign o_result.average = {{(OB-DB){1'b0}}, n_average};
            assign o_result.minimum = {{(OB-DB){1'b0}}, n_minimum};
            assign o_result.maximum = {{(OB-DB){1'b0}}, n_maximum};
            assign o_result.pending = {{(OB-DB){1'b0}}, pending};
        end
    endgenerate

    assign o_result.running       = n_in_progress;
    assign o_result.nonce_present = n_nonce_valid;
    assign o_result.nonce_out     = n_nonce_valid ? n_nonce_store : '0;

    // The moving average always lies between the running minimum and maximum.
    a_avg_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_minimum <= r_average) && (r_average <= r_maximum))
        else $error("average outside minimum/maximum");

    // A stored nonce is cleared together with its valid flag.
    a_nonce_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_nonce_valid |-> (r_nonce_store == '0))
        else $error("nonce left behind without valid flag");

    // A measurement only stops through an accepted end event.
    a_stop_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_in_progress))
            |-> $past(i_step && (i_opcode == lmem_pkg::OP_END)))
        else $error("measurement stopped without end event");

endmodule

// ===== hdl/latency_meter_ema_min_max_unit.sv =====
`timescale 1ns / 1ps

// Round-trip latency monitor with a moving average, minimum and maximum.
//
// Requests enter on the slave stream: tuser carries the event code (tick of
// one millisecond, start, end, set nonce) and tdata carries the nonce used by
// the set-nonce event. Every request yields exactly one result on the master
// stream, which reports the state after that request was applied.
//
// The smoothing weight alpha_q16 is written through i_cfg_wr_en/i_cfg_wr_data
// and must only be changed while no request is in flight.
//
// An accepted request passes through an input register and then a result
// register, with the state update between them. Throughput is one request
// per cycle while i_m_axis_tready stays high, set by the recurrence of the
// state update (one multiplier and compare path).
//
// Reset (synchronous, active low) clears all measurement state, restores
// alpha to 13107 and empties both registers. When the receiver stalls, the
// result register holds its value and the input register can still take one
// more request before o_s_axis_tready drops.

module latency_meter_ema_min_max_unit #(
    parameter int DURATION_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [63:0] nonce_value
    input  logic [lmem_pkg::S_TDATA_BITS-1:0]   i_s_axis_tdata,
    // [1:0] opcode
    input  logic [lmem_pkg::S_TUSER_BITS-1:0]   i_s_axis_tuser,
    // master stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [31:0] average_ms, [63:32] minimum_ms, [95:64] maximum_ms, [96] running,
    // [128:97] pending_ms, [129] nonce_present, [193:130] nonce_out, rest zero
    output logic [lmem_pkg::M_TDATA_BITS-1:0]   o_m_axis_tdata,
    // configuration: alpha_q16
    input  logic                                i_cfg_wr_en,
    input  logic [lmem_pkg::ALPHA_BITS-1:0]     i_cfg_wr_data
);

    localparam int RB = $bits(lmem_pkg::t_result);

    logic [lmem_pkg::ALPHA_BITS-1:0] r_alpha;

    // Input register.
    logic                            r_in_valid;
    lmem_pkg::t_opcode               r_in_opcode;
    logic [lmem_pkg::NONCE_BITS-1:0] r_in_nonce;

    // Result register.
    logic                            r_out_valid;
    lmem_pkg::t_result               r_out;

    lmem_pkg::t_result               core_result;
    logic                            advance;

    // The held request moves into the result register whenever that register
    // is empty or being drained in the same cycle.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= lmem_pkg::ALPHA_RESET;
        end else if (i_cfg_wr_en) begin
            r_alpha <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // Payload needs no reset; it is qualified by r_in_valid.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_opcode <= lmem_pkg::t_opcode'(i_s_axis_tuser);
            r_in_nonce  <= i_s_axis_tdata[lmem_pkg::NONCE_BITS-1:0];
        end
    end

    lmem_core #(
        .DURATION_BITS (DURATION_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_opcode (r_in_opcode),
        .i_nonce  (r_in_nonce),
        .i_alpha  (r_alpha),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {
        {(lmem_pkg::M_TDATA_BITS - RB){1'b0}},
        r_out.nonce_out,
        r_out.nonce_present,
        r_out.pending,
        r_out.running,
        r_out.maximum,
        r_out.minimum,
        r_out.average
    };

endmodule

// ===== dv/latency_meter_ema_min_max_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the latency monitor. Every accepted request is run
// through a local model of the monitor state, and the expected report goes
// into a queue. Each report that leaves the master stream is compared field
// by field with the oldest entry of that queue.
module latency_meter_ema_min_max_unit_tb;

    localparam int CLK_HALF_NS     = 4;
    localparam int RESET_CYCLES    = 5;
    localparam int DUR_BITS        = 32;
    // Acceptance to o_m_axis_tvalid, through the input and result registers.
    localparam int PIPE_LATENCY    = 2;
    // The longest stall on either side is bounded by idle_gap, so this is far
    // beyond any quiet stretch that a working block can show.
    localparam int QUIET_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 246;
    localparam int MAX_REPORTED    = 10;
    localparam logic [lmem_pkg::NONCE_BITS-1:0] ALL_ONES = '1;

    // One row of the directed table. Where typed is set, want is the report
    // written down by hand; otherwise the local model supplies it.
    typedef struct {
        lmem_pkg::t_opcode               op;
        logic [lmem_pkg::NONCE_BITS-1:0] nonce;
        bit                              typed;
        lmem_pkg::t_result               want;
    } t_directed_row;

    // Block ports. All inputs start at a known value at time zero.
    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              s_tvalid    = 1'b0;
    logic                              s_tready;
    logic [lmem_pkg::S_TDATA_BITS-1:0] s_tdata     = '0;
    logic [lmem_pkg::S_TUSER_BITS-1:0] s_tuser     = '0;
    logic                              m_tvalid;
    logic                              m_tready    = 1'b0;
    logic [lmem_pkg::M_TDATA_BITS-1:0] m_tdata;
    logic                              cfg_wr_en   = 1'b0;
    logic [lmem_pkg::ALPHA_BITS-1:0]   cfg_wr_data = '0;

    // Local copy of the monitor state and of the smoothing weight.
    logic [lmem_pkg::ALPHA_BITS-1:0] alpha_now;
    logic                            meter_busy;
    logic [DUR_BITS-1:0]             elapsed_ms;
    logic [DUR_BITS-1:0]             avg_ms;
    logic [DUR_BITS-1:0]             min_ms;
    logic [DUR_BITS-1:0]             max_ms;
    logic                            nonce_held;
    logic [lmem_pkg::NONCE_BITS-1:0] nonce_reg;
    bit                              event_ignored;

    lmem_pkg::t_result expected_reports[$];
    t_directed_row     directed_rows[$];

    // Idling is switched per phase so that some phases run back to back.
    bit sender_idle;
    bit receiver_idle;
    int stall_left;
    int quiet_cycles;

    int mismatches;
    int results_seen;
    int requests_sent;
    int useful_sent;
    int samples_done;
    int reloads;
    int decays;
    int alpha_writes;
    logic [DUR_BITS-1:0] longest_ms;

    latency_meter_ema_min_max_unit #(
        .DURATION_BITS(DUR_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    function automatic lmem_pkg::t_result make_result(
        input logic [lmem_pkg::OUT_BITS-1:0]   avg,
        input logic [lmem_pkg::OUT_BITS-1:0]   mn,
        input logic [lmem_pkg::OUT_BITS-1:0]   mx,
        input logic                            run,
        input logic [lmem_pkg::OUT_BITS-1:0]   pend,
        input logic                            np,
        input logic [lmem_pkg::NONCE_BITS-1:0] nv);
        lmem_pkg::t_result r;
        r.average       = avg;
        r.minimum       = mn;
        r.maximum       = mx;
        r.running       = run;
        r.pending       = pend;
        r.nonce_present = np;
        r.nonce_out     = nv;
        return r;
    endfunction

    task automatic reset_monitor_model();
        alpha_now  = lmem_pkg::ALPHA_RESET;
        meter_busy = 1'b0;
        elapsed_ms = '0;
        avg_ms     = '0;
        min_ms     = '0;
        max_ms     = '0;
        nonce_held = 1'b0;
        nonce_reg  = '0;
    endtask

    // Applies one request to the local state and returns the report that the
    // block must produce for it. event_ignored tells whether the request had
    // any effect at all.
    function automatic void apply_event(input lmem_pkg::t_opcode op,
                                        input logic [lmem_pkg::NONCE_BITS-1:0] nonce,
                                        output lmem_pkg::t_result r);
        logic [63:0] acc;
        event_ignored = 1'b0;
        case (op)
            lmem_pkg::OP_TICK: begin
                if (!meter_busy) begin
                    event_ignored = 1'b1;
                end else if (elapsed_ms != '1) begin
                    // The counter saturates instead of wrapping.
                    elapsed_ms = elapsed_ms + 1'b1;
                end
            end
            lmem_pkg::OP_START: begin
                if (meter_busy) begin
                    event_ignored = 1'b1;
                end else begin
                    elapsed_ms = '0;
                    meter_busy = 1'b1;
                end
            end
            lmem_pkg::OP_END: begin
                if (!meter_busy) begin
                    event_ignored = 1'b1;
                end else begin
                    meter_busy = 1'b0;
                    nonce_held = 1'b0;
                    nonce_reg  = '0;
                    samples_done++;
                    if (elapsed_ms > longest_ms) longest_ms = elapsed_ms;
                    if (avg_ms == '0) begin
                        // A zero average means no history: the sample reloads
                        // average, minimum and maximum.
                        avg_ms = elapsed_ms;
                        min_ms = elapsed_ms;
                        max_ms = elapsed_ms;
                        reloads++;
                    end else begin
                        acc = 64'(alpha_now) * 64'(elapsed_ms)
                            + (64'd65536 - 64'(alpha_now)) * 64'(avg_ms);
                        avg_ms = acc[47:16];
                        if (avg_ms == '0) decays++;
                        if (elapsed_ms < min_ms) min_ms = elapsed_ms;
                        if (elapsed_ms > max_ms) max_ms = elapsed_ms;
                    end
                end
            end
            default: begin
                nonce_reg  = nonce;
                nonce_held = 1'b1;
            end
        endcase
        r = make_result(avg_ms, min_ms, max_ms, meter_busy,
                        meter_busy ? elapsed_ms : '0,
                        nonce_held, nonce_held ? nonce_reg : '0);
    endfunction

    // Most gaps are zero or short, a few are long.
    function automatic int idle_gap(input bit enabled);
        int pick;
        if (!enabled) return 0;
        pick = $urandom_range(99);
        if (pick < 65) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [lmem_pkg::NONCE_BITS-1:0] pick_nonce();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTED) $display("MISMATCH: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            note_mismatch($sformatf("result %0d field %s expected 0x%0h got 0x%0h",
                                    results_seen, name, want, got));
        end
    endtask

    // Unpacks one report from tdata, lowest field first, and compares it with
    // the oldest expectation.
    task automatic check_report(input logic [lmem_pkg::M_TDATA_BITS-1:0] data);
        lmem_pkg::t_result want;
        results_seen++;
        if (expected_reports.size() == 0) begin
            note_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    results_seen));
            return;
        end
        want = expected_reports.pop_front();
        check_field("average_ms",    64'(want.average),       64'(data[31:0]));
        check_field("minimum_ms",    64'(want.minimum),       64'(data[63:32]));
        check_field("maximum_ms",    64'(want.maximum),       64'(data[95:64]));
        check_field("running",       64'(want.running),       64'(data[96]));
        check_field("pending_ms",    64'(want.pending),       64'(data[128:97]));
        check_field("nonce_present", 64'(want.nonce_present), 64'(data[129]));
        check_field("nonce_out",     want.nonce_out,          data[193:130]);
        check_field("padding",       64'd0,
                    64'(data[lmem_pkg::M_TDATA_BITS-1:194]));
    endtask

    // Offers one request, waits for its handshake and records the expected
    // report. tvalid stays high after acceptance when the next request follows
    // without a gap, so it never sees two assignments in one step.
    task automatic send_request(input lmem_pkg::t_opcode op,
                                input logic [lmem_pkg::NONCE_BITS-1:0] nonce,
                                input bit typed, input lmem_pkg::t_result want);
        int gap;
        lmem_pkg::t_result predicted;
        gap = idle_gap(sender_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= nonce;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        apply_event(op, nonce, predicted);
        expected_reports.push_back(typed ? want : predicted);
        requests_sent++;
        if (!event_ignored) useful_sent++;
    endtask

    task automatic add_row(input lmem_pkg::t_opcode op,
                           input logic [lmem_pkg::NONCE_BITS-1:0] nonce,
                           input bit typed, input lmem_pkg::t_result want);
        directed_rows.push_back('{op, nonce, typed, want});
    endtask

    // Directed part, run at the reset weight. Rows with a hand-written report
    // cover the idle cases, the ignored requests, the nonce extremes, a decay
    // of the average to zero and the reload that follows it.
    task automatic build_directed_table();
        // A tick and an end while idle change nothing.
        add_row(lmem_pkg::OP_TICK,  '0,       1'b1,
                make_result(0, 0, 0, 1'b0, 0, 1'b0, '0));
        add_row(lmem_pkg::OP_END,   ALL_ONES, 1'b1,
                make_result(0, 0, 0, 1'b0, 0, 1'b0, '0));
        add_row(lmem_pkg::OP_NONCE, ALL_ONES, 1'b1,
                make_result(0, 0, 0, 1'b0, 0, 1'b1, ALL_ONES));
        // An end while idle keeps the stored nonce.
        add_row(lmem_pkg::OP_END,   '0,       1'b1,
                make_result(0, 0, 0, 1'b0, 0, 1'b1, ALL_ONES));
        add_row(lmem_pkg::OP_START, '0,       1'b1,
                make_result(0, 0, 0, 1'b1, 0, 1'b1, ALL_ONES));
        // A second start is ignored and the elapsed count is kept.
        add_row(lmem_pkg::OP_START, '0,       1'b1,
                make_result(0, 0, 0, 1'b1, 0, 1'b1, ALL_ONES));
        add_row(lmem_pkg::OP_TICK,  '0,       1'b1,
                make_result(0, 0, 0, 1'b1, 1, 1'b1, ALL_ONES));
        add_row(lmem_pkg::OP_START, 64'hDEAD_BEEF_0123_4567, 1'b1,
                make_result(0, 0, 0, 1'b1, 1, 1'b1, ALL_ONES));
        // First sample loads all three statistics and drops the nonce.
        add_row(lmem_pkg::OP_END,   '0,       1'b1,
                make_result(1, 1, 1, 1'b0, 0, 1'b0, '0));
        add_row(lmem_pkg::OP_NONCE, '0,       1'b1,
                make_result(1, 1, 1, 1'b0, 0, 1'b1, '0));
        add_row(lmem_pkg::OP_START, '0,       1'b1,
                make_result(1, 1, 1, 1'b1, 0, 1'b1, '0));
        // A zero-length sample pulls an average of one down to zero.
        add_row(lmem_pkg::OP_END,   '0,       1'b1,
                make_result(0, 0, 1, 1'b0, 0, 1'b0, '0));
        add_row(lmem_pkg::OP_START, '0,       1'b1,
                make_result(0, 0, 1, 1'b1, 0, 1'b0, '0));
        add_row(lmem_pkg::OP_TICK,  '0,       1'b1,
                make_result(0, 0, 1, 1'b1, 1, 1'b0, '0));
        add_row(lmem_pkg::OP_TICK,  '0,       1'b1,
                make_result(0, 0, 1, 1'b1, 2, 1'b0, '0));
        add_row(lmem_pkg::OP_TICK,  '0,       1'b1,
                make_result(0, 0, 1, 1'b1, 3, 1'b0, '0));
        // With the average at zero the next sample reloads everything.
        add_row(lmem_pkg::OP_END,   '0,       1'b1,
                make_result(3, 3, 3, 1'b0, 0, 1'b0, '0));
        add_row(lmem_pkg::OP_NONCE, 64'h5555_5555_5555_5555, 1'b0, '0);
        add_row(lmem_pkg::OP_NONCE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);
        add_row(lmem_pkg::OP_START, ALL_ONES, 1'b0, '0);
        add_row(lmem_pkg::OP_TICK,  64'h0123_4567_89AB_CDEF, 1'b0, '0);
        add_row(lmem_pkg::OP_END,   '0,       1'b0, '0);
        add_row(lmem_pkg::OP_TICK,  ALL_ONES, 1'b0, '0);
    endtask

    // A well-formed measurement: start, a run of ticks, end, with a nonce set
    // now and then before or inside the run. The tick count is kept within
    // the room left in the current phase.
    task automatic run_measurement(input int room);
        int ticks;
        int pick;
        int nonce_at;
        pick = $urandom_range(99);
        if (pick < 10) ticks = 0;
        else if (pick < 85) ticks = $urandom_range(1, 20);
        else if (pick < 97) ticks = $urandom_range(21, 120);
        else ticks = $urandom_range(200, 600);
        if (ticks > room) ticks = room;
        nonce_at = ($urandom_range(2) == 0) ? $urandom_range(0, ticks) : -1;
        if ($urandom_range(9) == 0) begin
            send_request(lmem_pkg::OP_NONCE, pick_nonce(), 1'b0, '0);
        end
        send_request(lmem_pkg::OP_START, pick_nonce(), 1'b0, '0);
        for (int t = 0; t < ticks; t++) begin
            if (t == nonce_at) send_request(lmem_pkg::OP_NONCE, pick_nonce(), 1'b0, '0);
            send_request(lmem_pkg::OP_TICK, pick_nonce(), 1'b0, '0);
        end
        if (nonce_at == ticks) send_request(lmem_pkg::OP_NONCE, pick_nonce(), 1'b0, '0);
        send_request(lmem_pkg::OP_END, pick_nonce(), 1'b0, '0);
    endtask

    // Random requests of any kind: stray starts and ends, idle ticks, and
    // measurements left open across the next sequence.
    task automatic send_noise();
        int count;
        count = $urandom_range(1, 5);
        repeat (count) begin
            send_request(lmem_pkg::t_opcode'(2'($urandom_range(3))), pick_nonce(),
                         1'b0, '0);
        end
    endtask

    // Waits until every expected report has arrived and the pipeline is empty.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // The weight is only changed with nothing in flight.
    task automatic write_alpha(input logic [lmem_pkg::ALPHA_BITS-1:0] value);
        drain_pipeline();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        alpha_now = value;
        alpha_writes++;
    endtask

    // Receiver side: checks each accepted report and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) check_report(m_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = idle_gap(receiver_idle);
                m_tready <= (stall_left == 0);
            end
        end
    end

    // Watchdog: a run of cycles with no handshake on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d reports outstanding",
                     quiet_cycles, expected_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [lmem_pkg::ALPHA_BITS-1:0] alpha_plan[$];
        t_directed_row row;
        int phase_start;

        reset_monitor_model();
        longest_ms    = '0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        build_directed_table();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_request(row.op, row.nonce, row.typed, row.want);
        end

        // Weight settings for the random phases, extremes first. Zero is
        // accepted by the block even though it freezes a nonzero average.
        alpha_plan = {16'd65535, 16'd1, 16'd0, 16'($urandom_range(2, 65534)),
                      16'd32768, lmem_pkg::ALPHA_RESET, 16'($urandom_range(1, 65535))};
        foreach (alpha_plan[p]) begin
            write_alpha(alpha_plan[p]);
            // One phase runs with no idling at all on either side.
            sender_idle   = (p != 2) && ($urandom_range(3) != 0);
            receiver_idle = (p != 2) && ($urandom_range(3) != 0);
            phase_start = requests_sent;
            while (requests_sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 82) begin
                    run_measurement(ITEMS_PER_PHASE - (requests_sent - phase_start));
                end else begin
                    send_noise();
                end
            end
        end

        drain_pipeline();

        $display("Run summary: %0d requests (%0d directed, %0d with an effect), %0d %s",
                 requests_sent, directed_rows.size(), useful_sent, results_seen,
                 $sformatf("reports checked, %0d weight writes.", alpha_writes));
        $display("Measurements %0d, reloads %0d, decays to zero %0d, longest %0d ms, %s",
                 samples_done, reloads, decays, longest_ms,
                 $sformatf("mismatches %0d.", mismatches));
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== latency_meter_ema_min_max_unit.f =====
hdl/lmem_pkg.sv
hdl/lmem_core.sv
hdl/latency_meter_ema_min_max_unit.sv
dv/latency_meter_ema_min_max_unit_tb.sv
